>>> rtl/i2cm_pkg.sv
package i2cm_pkg;

    // Command codes on the op field
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT    = 1'd1;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd2;
    localparam logic [9:0] ACK_WAIT_RST    = 10'd250;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

    // Queue between the classifier and the sequencer
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_S1,
        PH_S2,
        PH_P1,
        PH_P2,
        PH_WL,
        PH_WH,
        PH_AL,
        PH_AH,
        PH_RL,
        PH_RH,
        PH_KL,
        PH_KH
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       check_ack;
        logic       nack_after_read;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_output_enable;
        logic       busy;
        logic       done;
        logic       no_ack;
        logic [7:0] rx_byte;
    } res_t;

endpackage

>>> rtl/i2cm_front.sv
module i2cm_front (
    input  logic [2:0]      op,
    input  logic [7:0]      tx_byte,
    input  logic            check_ack,
    input  logic            nack_after_read,
    input  logic            sda_in,
    output i2cm_pkg::item_t item
);
    import i2cm_pkg::*;

    cmd_t cmd;

    // Classify the op code; anything outside start..read is a bare tick
    always_comb
    begin
        case (op)
            OP_START: cmd = CMD_START;
            OP_STOP:  cmd = CMD_STOP;
            OP_WRITE: cmd = CMD_WRITE;
            OP_READ:  cmd = CMD_READ;
            default:  cmd = CMD_NONE;
        endcase
    end

    always_comb
    begin
        item.cmd             = cmd;
        item.tx_byte         = tx_byte;
        item.check_ack       = check_ack;
        item.nack_after_read = nack_after_read;
        item.sda_in          = sda_in;
    end

endmodule

>>> rtl/i2cm_queue.sv
module i2cm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  i2cm_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output i2cm_pkg::item_t pop_item
);
    import i2cm_pkg::*;

    item_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/i2cm_back.sv
module i2cm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  i2cm_pkg::item_t item,
    input  logic [7:0]      half_period,
    input  logic [9:0]      ack_wait_limit,
    output logic            out_valid,
    input  logic            out_ready,
    output i2cm_pkg::res_t  res
);
    import i2cm_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] bit_count_reg;
    logic [3:0] bit_count_next;
    logic [7:0] shift_reg;
    logic [7:0] shift_next;
    logic [7:0] tick_count_reg;
    logic [7:0] tick_count_next;
    logic [9:0] ack_count_reg;
    logic [9:0] ack_count_next;
    logic       scl_reg;
    logic       scl_next;
    logic       sda_reg;
    logic       sda_next;
    logic       sda_dir_reg;
    logic       sda_dir_next;
    logic       check_ack_reg;
    logic       check_ack_next;
    logic       nack_reg;
    logic       nack_next;
    logic       abort_reg;
    logic       abort_next;
    logic [7:0] rx_hold_reg;
    logic [7:0] rx_hold_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       res_reg;
    logic       done;
    logic       no_ack_flag;

    logic       step;
    logic [7:0] hp;
    logic [7:0] tick_inc;
    logic       phase_end;
    logic [3:0] bit_inc;
    logic       more_bits;
    logic [9:0] ack_inc;
    logic       ack_timeout;

    // Take one tick whenever the output register is free or drains now
    assign item_ready  = !out_valid_reg || out_ready;
    assign step        = item_valid && item_ready;

    assign hp          = (half_period == '0) ? 8'd1 : half_period;
    assign tick_inc    = tick_count_reg + 8'd1;
    assign phase_end   = (tick_inc >= hp);
    assign bit_inc     = bit_count_reg + 4'd1;
    assign more_bits   = (bit_inc < BITS_PER_BYTE);
    assign ack_inc     = ack_count_reg + 10'd1;
    assign ack_timeout = (ack_inc >= ack_wait_limit);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                case (item.cmd)
                    CMD_START: phase_next = PH_S1;
                    CMD_STOP:  phase_next = PH_P1;
                    CMD_WRITE: phase_next = PH_WL;
                    CMD_READ:  phase_next = PH_RL;
                    default:   phase_next = PH_IDLE;
                endcase
            end
            PH_AH:
            begin
                if (!item.sda_in)
                begin
                    phase_next = PH_IDLE;
                end
                else if (ack_timeout)
                begin
                    phase_next = PH_P1;
                end
            end
            default:
            begin
                if (phase_end)
                begin
                    case (phase_reg)
                        PH_S1: phase_next = PH_S2;
                        PH_P1: phase_next = PH_P2;
                        PH_WL: phase_next = PH_WH;
                        PH_WH: phase_next = more_bits ? PH_WL :
                                            (check_ack_reg ? PH_AL : PH_IDLE);
                        PH_AL: phase_next = PH_AH;
                        PH_RL: phase_next = PH_RH;
                        PH_RH: phase_next = more_bits ? PH_RL : PH_KL;
                        PH_KL: phase_next = PH_KH;
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Line levels, counters and completion flags
    always_comb
    begin
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        ack_count_next  = ack_count_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_dir_next    = sda_dir_reg;
        check_ack_next  = check_ack_reg;
        nack_next       = nack_reg;
        abort_next      = abort_reg;
        rx_hold_next    = rx_hold_reg;
        done            = 1'b0;
        no_ack_flag     = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (item.cmd != CMD_NONE)
                begin
                    check_ack_next  = item.check_ack;
                    nack_next       = item.nack_after_read;
                    abort_next      = 1'b0;
                    bit_count_next  = '0;
                    tick_count_next = '0;
                    case (item.cmd)
                        CMD_START:
                        begin
                            scl_next     = 1'b1;
                            sda_next     = 1'b1;
                            sda_dir_next = 1'b1;
                        end
                        CMD_STOP:
                        begin
                            scl_next     = 1'b0;
                            sda_next     = 1'b0;
                            sda_dir_next = 1'b1;
                        end
                        CMD_WRITE:
                        begin
                            shift_next   = item.tx_byte;
                            scl_next     = 1'b0;
                            sda_next     = item.tx_byte[7];
                            sda_dir_next = 1'b1;
                        end
                        default:
                        begin
                            shift_next   = '0;
                            scl_next     = 1'b0;
                            sda_next     = 1'b1;
                            sda_dir_next = 1'b0;
                        end
                    endcase
                end
            end
            PH_AH:
            begin
                if (!item.sda_in)
                begin
                    scl_next        = 1'b0;
                    tick_count_next = '0;
                    done            = 1'b1;
                end
                else
                begin
                    ack_count_next = ack_inc;
                    if (ack_timeout)
                    begin
                        abort_next      = 1'b1;
                        scl_next        = 1'b0;
                        sda_next        = 1'b0;
                        sda_dir_next    = 1'b1;
                        tick_count_next = '0;
                    end
                end
            end
            default:
            begin
                tick_count_next = tick_inc;
                if (phase_end)
                begin
                    tick_count_next = '0;
                    case (phase_reg)
                        PH_S1:
                        begin
                            scl_next     = 1'b1;
                            sda_next     = 1'b0;
                            sda_dir_next = 1'b1;
                        end
                        PH_S2:
                        begin
                            scl_next = 1'b0;
                            done     = 1'b1;
                        end
                        PH_P1:
                        begin
                            scl_next     = 1'b1;
                            sda_next     = 1'b1;
                            sda_dir_next = 1'b1;
                        end
                        PH_P2:
                        begin
                            done        = 1'b1;
                            no_ack_flag = abort_reg;
                            abort_next  = 1'b0;
                        end
                        PH_WL, PH_KL:
                        begin
                            scl_next     = 1'b1;
                            sda_dir_next = 1'b1;
                        end
                        PH_WH:
                        begin
                            bit_count_next = bit_inc;
                            shift_next     = {shift_reg[6:0], 1'b0};
                            scl_next       = 1'b0;
                            if (more_bits)
                            begin
                                sda_next     = shift_reg[6];
                                sda_dir_next = 1'b1;
                            end
                            else if (check_ack_reg)
                            begin
                                sda_next     = 1'b1;
                                sda_dir_next = 1'b0;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        PH_AL:
                        begin
                            scl_next       = 1'b1;
                            sda_next       = 1'b1;
                            sda_dir_next   = 1'b0;
                            ack_count_next = '0;
                        end
                        PH_RL:
                        begin
                            // sample on the first tick of SCL high
                            scl_next     = 1'b1;
                            sda_next     = 1'b1;
                            sda_dir_next = 1'b0;
                            shift_next   = {shift_reg[6:0], item.sda_in};
                        end
                        PH_RH:
                        begin
                            bit_count_next = bit_inc;
                            scl_next       = 1'b0;
                            if (more_bits)
                            begin
                                sda_next     = 1'b1;
                                sda_dir_next = 1'b0;
                            end
                            else
                            begin
                                sda_next     = nack_reg;
                                sda_dir_next = 1'b1;
                            end
                        end
                        PH_KH:
                        begin
                            scl_next     = 1'b0;
                            rx_hold_next = shift_reg;
                            done         = 1'b1;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            tick_count_reg <= '0;
            ack_count_reg  <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            sda_dir_reg    <= 1'b0;
            check_ack_reg  <= 1'b0;
            nack_reg       <= 1'b0;
            abort_reg      <= 1'b0;
            rx_hold_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                tick_count_reg <= tick_count_next;
                ack_count_reg  <= ack_count_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                sda_dir_reg    <= sda_dir_next;
                check_ack_reg  <= check_ack_next;
                nack_reg       <= nack_next;
                abort_reg      <= abort_next;
                rx_hold_reg    <= rx_hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg.scl_level         <= scl_next;
            res_reg.sda_level         <= sda_next;
            res_reg.sda_output_enable <= sda_dir_next;
            res_reg.busy              <= (phase_next != PH_IDLE);
            res_reg.done              <= done;
            res_reg.no_ack            <= no_ack_flag;
            res_reg.rx_byte           <= rx_hold_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/i2c_master_byte_engine_core.sv
// Channel  | Handshake             | Beat contents
// ---------+-----------------------+------------------------------------------------
// in       | in_valid / in_ready   | op, tx_byte, check_ack, nack_after_read, sda_in
// out      | out_valid / out_ready | scl_level, sda_level, sda_output_enable,
//          |                       | busy_res, done_res, no_ack, rx_byte
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (0 half_period, 1 ack limit)
//
// One input beat is one bus tick and yields exactly one output beat.
// Sustained rate is one beat per clock while out does not stall: the classifier
// feeds a two-beat queue, the sequencer steps once per clock into its output
// register. Reset (rst_n, async, active low) returns to idle with SCL high and
// SDA released; cfg is always ready. A stall on out holds the sequencer, and the
// queue keeps taking input until it fills.
module i2c_master_byte_engine_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        op,
    input  logic [7:0]                        tx_byte,
    input  logic                              check_ack,
    input  logic                              nack_after_read,
    input  logic                              sda_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              scl_level,
    output logic                              sda_level,
    output logic                              sda_output_enable,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              no_ack,
    output logic [7:0]                        rx_byte,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import i2cm_pkg::*;

    item_t      front_item;
    item_t      q_item;
    logic       q_valid;
    logic       q_ready;
    res_t       res;
    logic [7:0] half_period_reg;
    logic [7:0] half_period_next;
    logic [9:0] ack_wait_reg;
    logic [9:0] ack_wait_next;

    // Config writes are registered; the host is to write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_comb
    begin
        half_period_next = half_period_reg;
        ack_wait_next    = ack_wait_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_period_next = cfg_data[7:0];
                CFG_ACK_WAIT:    ack_wait_next    = cfg_data[9:0];
                default:         half_period_next = half_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
            ack_wait_reg    <= ACK_WAIT_RST;
        end
        else
        begin
            half_period_reg <= half_period_next;
            ack_wait_reg    <= ack_wait_next;
        end
    end

    // Front: decode op into a command
    i2cm_front u_front (
        .op              (op),
        .tx_byte         (tx_byte),
        .check_ack       (check_ack),
        .nack_after_read (nack_after_read),
        .sda_in          (sda_in),
        .item            (front_item)
    );

    // Queue: decouple input acceptance from the sequencer
    i2cm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Back: bit-level sequencer with registered output beat
    i2cm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (q_valid),
        .item_ready     (q_ready),
        .item           (q_item),
        .half_period    (half_period_reg),
        .ack_wait_limit (ack_wait_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .res            (res)
    );

    assign scl_level         = res.scl_level;
    assign sda_level         = res.sda_level;
    assign sda_output_enable = res.sda_output_enable;
    assign busy_res          = res.busy;
    assign done_res          = res.done;
    assign no_ack            = res.no_ack;
    assign rx_byte           = res.rx_byte;

    // A completed command leaves the engine idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // no_ack only comes with done
    a_noack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_ack |-> done_res)
        else $error("no_ack without done");

    // SDA is always released whenever the master is not driving it
    a_sda_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sda_output_enable |-> sda_level)
        else $error("sda low while not driven");

    // A stalled output beat holds the sequencer state visible on the port
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(busy_res) && $stable(rx_byte))
        else $error("output beat changed under stall");

endmodule

>>> test/tb_i2c_master_byte_engine_core.sv
module tb_i2c_master_byte_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // Op codes the engine must treat as a plain tick when idle
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Run limits, in clocks and tick beats
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CLOCKS  = 8;
    localparam int ITEMS_PER_SET = 15;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = OP_TICK;
    logic [7:0]  tx_byte = 8'd0;
    logic        check_ack = 1'b0;
    logic        nack_after_read = 1'b0;
    logic        sda_in = 1'b1;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        scl_level;
    logic        sda_level;
    logic        sda_output_enable;
    logic        busy_res;
    logic        done_res;
    logic        no_ack;
    logic [7:0]  rx_byte;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted line levels and status, one entry per accepted tick beat
    res_t tick_results_q[$];

    int fail_count = 0;
    int cycles = 0;
    int item_count = 0;
    bit calm = 1'b0;    // when set, neither side idles

    // Shadow of the byte engine: sequencer state and both registers
    phase_t      eng_phase;
    logic [3:0]  eng_bits;
    logic [7:0]  eng_shift;
    logic [7:0]  eng_ticks;
    logic [9:0]  eng_polls;
    logic        eng_scl;
    logic        eng_sda;
    logic        eng_drive;
    logic [4:0]  eng_cmd;
    logic        eng_abort;
    logic [7:0]  eng_rx;
    logic [7:0]  reg_half;
    logic [9:0]  reg_ack_limit;
    logic        tick_done;
    logic        tick_no_ack;

    i2c_master_byte_engine_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .tx_byte           (tx_byte),
        .check_ack         (check_ack),
        .nack_after_read   (nack_after_read),
        .sda_in            (sda_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .scl_level         (scl_level),
        .sda_level         (sda_level),
        .sda_output_enable (sda_output_enable),
        .busy_res          (busy_res),
        .done_res          (done_res),
        .no_ack            (no_ack),
        .rx_byte           (rx_byte),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bus sequencer shadow
    // ------------------------------------------------------------------

    function void reset_engine();
        reg_half      = HALF_PERIOD_RST;
        reg_ack_limit = ACK_WAIT_RST;
        eng_phase     = PH_IDLE;
        eng_bits      = '0;
        eng_shift     = '0;
        eng_ticks     = '0;
        eng_polls     = '0;
        eng_scl       = 1'b1;
        eng_sda       = 1'b1;
        eng_drive     = 1'b0;
        eng_cmd       = '0;
        eng_abort     = 1'b0;
        eng_rx        = '0;
    endfunction

    // Enter a phase with its line levels set on this tick
    function void enter_phase(phase_t p, logic scl, logic sda, logic drive);
        eng_phase = p;
        eng_scl   = scl;
        eng_sda   = sda;
        eng_drive = drive;
        eng_ticks = '0;
    endfunction

    function void finish_cmd();
        eng_phase = PH_IDLE;
        eng_ticks = '0;
        tick_done = 1'b1;
    endfunction

    // Leave the current phase once its half period has run out
    function void advance_phase();
        case (eng_phase)
            PH_S1: enter_phase(PH_S2, 1'b1, 1'b0, 1'b1);
            PH_S2:
            begin
                eng_scl = 1'b0;
                finish_cmd();
            end
            PH_P1: enter_phase(PH_P2, 1'b1, 1'b1, 1'b1);
            PH_P2:
            begin
                finish_cmd();
                tick_no_ack = eng_abort;
                eng_abort   = 1'b0;
            end
            PH_WL: enter_phase(PH_WH, 1'b1, eng_sda, 1'b1);
            PH_WH:
            begin
                eng_bits  = eng_bits + 4'd1;
                eng_shift = {eng_shift[6:0], 1'b0};
                if (eng_bits < BITS_PER_BYTE)
                    enter_phase(PH_WL, 1'b0, eng_shift[7], 1'b1);
                else if (eng_cmd[3])
                    enter_phase(PH_AL, 1'b0, 1'b1, 1'b0);
                else
                begin
                    // no ack check: end with SCL low, SDA still driven
                    eng_scl = 1'b0;
                    finish_cmd();
                end
            end
            PH_AL:
            begin
                enter_phase(PH_AH, 1'b1, 1'b1, 1'b0);
                eng_polls = '0;
            end
            PH_RL: enter_phase(PH_RH, 1'b1, 1'b1, 1'b0);
            PH_RH:
            begin
                eng_bits = eng_bits + 4'd1;
                if (eng_bits < BITS_PER_BYTE)
                    enter_phase(PH_RL, 1'b0, 1'b1, 1'b0);
                else
                    enter_phase(PH_KL, 1'b0, eng_cmd[4], 1'b1);
            end
            PH_KL: enter_phase(PH_KH, 1'b1, eng_sda, 1'b1);
            PH_KH:
            begin
                eng_scl = 1'b0;
                eng_rx  = eng_shift;
                finish_cmd();
            end
            default: finish_cmd();
        endcase
    endfunction

    // One bus tick: returns the levels and status the engine shows after it
    function res_t predict_tick(logic [2:0] c, logic [7:0] b, logic ca, logic nk,
                                logic sda);
        res_t r;
        logic [7:0] half;
        half        = (reg_half == 8'd0) ? 8'd1 : reg_half;
        tick_done   = 1'b0;
        tick_no_ack = 1'b0;
        if (eng_phase == PH_IDLE)
        begin
            if (c >= OP_START && c <= OP_READ)
            begin
                eng_cmd   = {nk, ca, c};
                eng_abort = 1'b0;
                eng_bits  = '0;
                case (c)
                    OP_START: enter_phase(PH_S1, 1'b1, 1'b1, 1'b1);
                    OP_STOP:  enter_phase(PH_P1, 1'b0, 1'b0, 1'b1);
                    OP_WRITE:
                    begin
                        eng_shift = b;
                        enter_phase(PH_WL, 1'b0, b[7], 1'b1);
                    end
                    default:
                    begin
                        eng_shift = '0;
                        enter_phase(PH_RL, 1'b0, 1'b1, 1'b0);
                    end
                endcase
            end
        end
        else if (eng_phase == PH_AH)
        begin
            if (!sda)
            begin
                eng_scl = 1'b0;
                finish_cmd();
            end
            else
            begin
                eng_polls = eng_polls + 10'd1;
                if (eng_polls >= reg_ack_limit)
                begin
                    // slave stayed silent: abort with a stop of our own
                    eng_abort = 1'b1;
                    enter_phase(PH_P1, 1'b0, 1'b0, 1'b1);
                end
            end
        end
        else
        begin
            eng_ticks = eng_ticks + 8'd1;
            if (eng_ticks >= half)
            begin
                advance_phase();
                // read bits are sampled on the first tick of SCL high
                if (eng_phase == PH_RH && eng_ticks == 8'd0)
                    eng_shift = {eng_shift[6:0], sda};
            end
        end
        r.scl_level         = eng_scl;
        r.sda_level         = eng_sda;
        r.sda_output_enable = eng_drive;
        r.busy              = (eng_phase != PH_IDLE);
        r.done              = tick_done;
        r.no_ack            = tick_no_ack;
        r.rx_byte           = eng_rx;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Receiver side: stall about a third of the clocks unless calm
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 33);

    // Drive one tick beat and hold it until taken; enter and leave on a falling edge
    task automatic send_item(logic [2:0] c, logic [7:0] b, logic ca, logic nk, logic sda);
        while (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        op              <= c;
        tx_byte         <= b;
        check_ack       <= ca;
        nack_after_read <= nk;
        sda_in          <= sda;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        item_count++;
        tick_results_q.push_back(predict_tick(c, b, ca, nk, sda));
    endtask

    // SDA seen by the engine: during the ack poll a slave answers now and then,
    // or never when it is silent; elsewhere the line is noise
    function automatic logic line_sample(bit silent);
        if (eng_phase == PH_AH)
            return silent ? 1'b1 : ($urandom_range(2) == 0 ? 1'b0 : 1'b1);
        return 1'($urandom_range(1));
    endfunction

    // Issue one command while idle, then tick until the engine is idle again;
    // ops sent while busy are random and must be ignored
    task automatic run_cmd(logic [2:0] c, logic [7:0] b, logic ca, logic nk, bit silent);
        send_item(c, b, ca, nk, 1'($urandom_range(1)));
        while (eng_phase != PH_IDLE)
            send_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)), line_sample(silent));
    endtask

    // A tick with no command: op zero or one of the spare codes
    task automatic idle_tick();
        logic [2:0] c;
        c = ($urandom_range(1) == 0) ? OP_TICK
                                     : 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        send_item(c, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    // Write a register with the engine idle and the pipe drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        while (eng_phase != PH_IDLE)
            send_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)), line_sample(1'b0));
        in_valid <= 1'b0;
        while (tick_results_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_HALF_PERIOD)
            reg_half = data[7:0];
        else
            reg_ack_limit = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every op at the reset settings: spare codes, start, writes with and
    // without ack check, reads with ack and nack, stop
    task automatic test_reset_settings();
        logic [2:0] c;
        idle_tick();
        for (c = OP_SPARE_FIRST; c != OP_TICK; c++)
            send_item(c, 8'hFF, 1'b1, 1'b1, 1'b0);
        run_cmd(OP_START, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b1, 1'b0, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0);
        run_cmd(OP_READ, 8'hFF, 1'b0, 1'b0, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b1, 1'b1, 1'b0);
        run_cmd(OP_STOP, 8'h55, 1'b1, 1'b0, 1'b0);
        idle_tick();
    endtask

    // Zero half period acts as one tick; zero ack limit aborts on the first
    // failed poll. Upper data bits on the half period write are dropped.
    task automatic test_zero_settings();
        write_reg(CFG_HALF_PERIOD, 10'h300);
        write_reg(CFG_ACK_WAIT, 10'h000);
        run_cmd(OP_START, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(OP_WRITE, 8'h5A, 1'b1, 1'b0, 1'b1);
        run_cmd(OP_READ, 8'h00, 1'b0, 1'b1, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // Widest ack limit with a slave that answers; the half period write
    // carries upper bits that must be dropped, leaving one tick
    task automatic test_max_settings();
        write_reg(CFG_HALF_PERIOD, 10'h301);
        write_reg(CFG_ACK_WAIT, 10'h3FF);
        run_cmd(OP_START, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(OP_WRITE, 8'hC3, 1'b1, 1'b0, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // Start, addressed write with ack check, maybe a data byte, stop;
    // now and then drop the stop to leave a broken transfer
    task automatic bus_transfer();
        int n;
        n = $urandom_range(1);
        run_cmd(OP_START, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
        run_cmd(OP_WRITE, 8'($urandom), 1'b1, 1'($urandom_range(1)),
                $urandom_range(4) == 0);
        repeat (n)
        begin
            if ($urandom_range(1))
                run_cmd(OP_WRITE, 8'($urandom), $urandom_range(3) != 0,
                        1'($urandom_range(1)), $urandom_range(5) == 0);
            else
                run_cmd(OP_READ, 8'($urandom), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'b0);
        end
        if ($urandom_range(9) != 0)
            run_cmd(OP_STOP, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'b0);
    endtask

    // Mostly well-formed transfers, the rest lone commands and idle ticks
    task automatic test_random_traffic(logic [7:0] half, logic [9:0] limit, bit no_gaps);
        int stop_at;
        write_reg(CFG_HALF_PERIOD, {2'($urandom_range(3)), half});
        write_reg(CFG_ACK_WAIT, limit);
        calm    = no_gaps;
        stop_at = item_count + ITEMS_PER_SET;
        while (item_count < stop_at)
        begin
            case ($urandom_range(9))
                0, 1:
                    run_cmd(3'($urandom_range(OP_READ, OP_START)), 8'($urandom),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            $urandom_range(3) == 0);
                2:
                    repeat ($urandom_range(4)) idle_tick();
                default:
                    bus_transfer();
            endcase
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each taken result beat against the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tick_results_q.size() == 0)
            begin
                $display("%0t: result beat with nothing predicted", $time);
                fail_count++;
            end
            else
            begin
                want = tick_results_q.pop_front();
                compare_field("scl_level", want.scl_level, scl_level);
                compare_field("sda_level", want.sda_level, sda_level);
                compare_field("sda_output_enable", want.sda_output_enable,
                              sda_output_enable);
                compare_field("busy_res", want.busy, busy_res);
                compare_field("done_res", want.done, done_res);
                compare_field("no_ack", want.no_ack, no_ack);
                compare_field("rx_byte", want.rx_byte, rx_byte);
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results pending", $time,
                     tick_results_q.size());
            $display("** i2c_master_byte_engine_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        reset_engine();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_reset_settings();
        test_zero_settings();
        test_max_settings();
        test_random_traffic(8'd1, 10'd1, 1'b1);
        test_random_traffic(8'd2, 10'd4, 1'b0);
        test_random_traffic(8'($urandom_range(2, 1)), 10'($urandom_range(10, 1)), 1'b0);
        test_random_traffic(8'd1, 10'($urandom_range(3)), 1'b0);

        // drop valid, let every predicted beat come back, then settle
        in_valid <= 1'b0;
        while (tick_results_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CLOCKS) @(negedge clk);
        if (fail_count == 0)
            $display("** i2c_master_byte_engine_core: PASSED **");
        else
            $display("** i2c_master_byte_engine_core: FAILED **");
        $finish;
    end

endmodule
